// ===== hdl/polled_alarm_table_core_macros.svh =====
// Assertion macros for the alarm table core.
`ifndef POLLED_ALARM_TABLE_CORE_MACROS_SVH
`define POLLED_ALARM_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PAT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PAT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PAT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/pat_pkg.sv =====
// ---------------------------------------------------------------------------
// Alarm table package
// Types, codes and constants shared by the alarm table modules.
// ---------------------------------------------------------------------------
`default_nettype none
package pat_pkg;
   localparam int ALARMS = 16;
   localparam int SLOT_W = $clog2(ALARMS);
   localparam int CNT_W = $clog2(ALARMS + 1);
   localparam int MAX_OUT = 16;
   localparam logic [31:0] TMAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      KIND_REG = 3'd0, KIND_DEREG = 3'd1, KIND_SET = 3'd2,
      KIND_CANCEL = 3'd3, KIND_TICK = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_BADID = 3'd1, ST_NOTREG = 3'd2, ST_NOTSET = 3'd3,
      ST_DUP = 3'd4, ST_FULL = 3'd5, ST_BADSTART = 3'd6
   } status_type;

   localparam logic CSR_MIN = 1'b0;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] timer_id;
      logic [31:0] now_secs;
      logic        start_now;
      logic [31:0] start_secs;
      logic [31:0] period_secs;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  alarm_count;
      logic [31:0] secs_left;
      logic        fired;
      logic [15:0] fired_id;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_APPLY, S_CMD_RSP, S_TICK_WALK, S_TICK_EMIT,
      S_RC_SLOT, S_RC_DIV, S_RC_ADV, S_RC_FIN, S_RSP_WAIT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_req;     // capture the request
      logic clr_idx;      // slot index to zero
      logic inc_idx;      // next slot
      logic scan_step;    // look at the current slot for find logic
      logic apply;        // do the command update
      logic tick_fire;    // reload or clear the current slot
      logic emit;         // load a fired beat into the output register
      logic cmd_emit;     // load the command result beat
      logic rc_init;      // start recompute
      logic rc_slot;      // evaluate current slot (no advance needed)
      logic div_start;
      logic rc_adv;       // write advanced due time
      logic rc_fin;       // write check time
      logic mark_last;    // set last on pending fired beat
   } ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_tick;
      logic is_skip;      // no recompute, immediate response
      logic ignore;       // undefined kind, or tick before check time or with no check time
      logic idx_last;
      logic slot_due_now; // tick: slot is due
      logic slot_armed;
      logic slot_overdue; // recompute: periodic and past now
      logic div_done;
      logic have_pend;    // fired beat being held
   } sts_type;
endpackage
`default_nettype wire

// ===== hdl/pat_div.sv =====
// ---------------------------------------------------------------------------
// Alarm table divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module pat_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {rem_ff, quo_ff[31]};
      if (start) begin
         rem_in = '0; quo_in = dividend; dvs_in = divisor;
         cnt_in = 6'd32; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 32'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = busy_ff && cnt_ff == 6'd1;
   assign quotient = quo_in;
endmodule
`default_nettype wire

// ===== hdl/pat_ctrl.sv =====
// ---------------------------------------------------------------------------
// Alarm table controller
// Sequences scan, update, tick walk and recompute over the slots.
// ---------------------------------------------------------------------------
`default_nettype none
module pat_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             out_busy,
   input  wire pat_pkg::sts_type sts,
   output pat_pkg::ctl_type      ctl
);
   import pat_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_SCAN;
         S_SCAN: begin
            if (sts.ignore) state_in = S_IDLE;
            else if (sts.is_skip) state_in = S_CMD_RSP;
            else if (sts.is_tick) state_in = S_TICK_WALK;
            else if (sts.idx_last) state_in = S_APPLY;
         end
         S_APPLY: state_in = S_RC_SLOT;
         S_TICK_WALK: begin
            if (sts.slot_due_now && !out_busy) state_in = S_TICK_EMIT;
            else if (!sts.slot_due_now && sts.idx_last) state_in = S_RC_SLOT;
         end
         S_TICK_EMIT: state_in = sts.idx_last ? S_RC_SLOT : S_TICK_WALK;
         S_RC_SLOT: begin
            if (sts.slot_overdue) state_in = S_RC_DIV;
            else if (sts.idx_last) state_in = S_RC_FIN;
         end
         S_RC_DIV: if (sts.div_done) state_in = S_RC_ADV;
         S_RC_ADV: state_in = sts.idx_last ? S_RC_FIN : S_RC_SLOT;
         S_RC_FIN: state_in = sts.is_tick ? S_RSP_WAIT : S_CMD_RSP;
         S_CMD_RSP: if (!out_busy) state_in = S_IDLE;
         S_RSP_WAIT: if (!out_busy || !sts.have_pend) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            ctl.load_req = req_valid;
            ctl.clr_idx = 1'b1;
         end
         S_SCAN: begin
            ctl.scan_step = 1'b1;
            if (sts.is_tick || sts.idx_last) ctl.clr_idx = 1'b1;
            else ctl.inc_idx = 1'b1;
         end
         S_APPLY: begin
            ctl.apply = 1'b1;
            ctl.rc_init = 1'b1;
            ctl.clr_idx = 1'b1;
         end
         S_TICK_WALK: begin
            if (!sts.slot_due_now) begin
               if (sts.idx_last) begin
                  ctl.clr_idx = 1'b1;
                  ctl.rc_init = 1'b1;
               end else ctl.inc_idx = 1'b1;
            end
         end
         S_TICK_EMIT: begin
            ctl.emit = 1'b1;
            ctl.tick_fire = 1'b1;
            if (sts.idx_last) begin
               ctl.clr_idx = 1'b1;
               ctl.rc_init = 1'b1;
            end else ctl.inc_idx = 1'b1;
         end
         S_RC_SLOT: begin
            ctl.rc_slot = 1'b1;
            if (sts.slot_overdue) ctl.div_start = 1'b1;
            else if (!sts.idx_last) ctl.inc_idx = 1'b1;
         end
         S_RC_ADV: begin
            ctl.rc_adv = 1'b1;
            if (!sts.idx_last) ctl.inc_idx = 1'b1;
         end
         S_RC_FIN: ctl.rc_fin = 1'b1;
         S_CMD_RSP: ctl.cmd_emit = !out_busy;
         S_RSP_WAIT: ctl.mark_last = !out_busy;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ===== hdl/pat_dp.sv =====
// ---------------------------------------------------------------------------
// Alarm table datapath
// Slot registers, request capture, recompute arithmetic and result staging.
// ---------------------------------------------------------------------------
`default_nettype none
module pat_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pat_pkg::req_type req_payload,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [31:0]      csr_wdata,
   input  wire pat_pkg::ctl_type ctl,
   output pat_pkg::sts_type      sts,
   input  wire logic             rsp_stall,
   output logic                  rsp_valid,
   output pat_pkg::rsp_type      rsp_payload
);
   import pat_pkg::*;

   logic [15:0] slot_id_ff  [ALARMS];
   logic [31:0] slot_due_ff [ALARMS];
   logic [31:0] slot_per_ff [ALARMS];
   logic [CNT_W-1:0] count_ff;
   logic [31:0] check_ff, min_ff, max_ff;
   req_type     req_ff;
   logic [SLOT_W-1:0] idx_ff;
   // Find results from the scan.
   logic        hit_ff, free_ok_ff;
   logic [SLOT_W-1:0] hit_idx_ff, free_idx_ff;
   logic        any_ff;
   logic [31:0] least_ff;
   logic [4:0]  nout_ff;
   // Command result and pending fired beat.
   logic [2:0]  cst_ff;
   logic [4:0]  ccnt_ff;
   logic [31:0] crem_ff;
   logic        pend_ff;
   logic [15:0] pend_id_ff;
   logic        ov_ff;
   rsp_type     out_ff;

   logic [31:0] now, eff_start, due, per, quo, adv_due;
   logic [15:0] sid;
   logic        div_done, armed;
   logic [63:0] prod;
   logic [32:0] sum;

   assign now = req_ff.now_secs;
   assign eff_start = req_ff.start_now ? now : req_ff.start_secs;
   assign sid = slot_id_ff[idx_ff];
   assign due = slot_due_ff[idx_ff];
   assign per = slot_per_ff[idx_ff];
   assign armed = sid != 16'd0 && due != 32'd0;

   pat_div u_div (
      .clock(clock), .reset(reset), .start(ctl.div_start),
      .dividend(now - due), .divisor(per), .done(div_done), .quotient(quo));

   logic [31:0] quo_ff;
   always_ff @(posedge clock) if (div_done) quo_ff <= quo;
   // (q+1)*p fits 64 bits; saturating add after.
   assign prod = ({32'd0, quo_ff} + 64'd1) * {32'd0, per};
   assign adv_due = (prod[63:32] != 32'd0) ? TMAX
      : (({1'b0, due} + {1'b0, prod[31:0]}) > {1'b0, TMAX}) ? TMAX
      : 32'(due + prod[31:0]);
   assign sum = {1'b0, due} + {1'b0, per};

   always_comb begin
      sts = '0;
      sts.is_tick = req_ff.kind == KIND_TICK;
      sts.ignore = req_ff.kind > KIND_TICK ||
         (sts.is_tick && (check_ff == 32'd0 || check_ff > now));
      sts.is_skip = !sts.is_tick && !sts.ignore &&
         (req_ff.timer_id == 16'd0 ||
          (req_ff.kind == KIND_SET && eff_start < now));
      sts.idx_last = idx_ff == SLOT_W'(ALARMS - 1);
      sts.slot_due_now = armed && due <= now;
      sts.slot_armed = armed;
      sts.slot_overdue = armed && due < now && per != 32'd0;
      sts.div_done = div_done;
      sts.have_pend = pend_ff;
   end

   logic [31:0] rem_c, least_c, delay;
   logic [32:0] ck;
   always_comb begin
      rem_c = due > now ? due - now : 32'd0;
      least_c = least_ff;
      if (!any_ff || rem_c < least_ff) least_c = rem_c;
      delay = least_ff == 32'd0 ? min_ff : (least_ff > max_ff ? max_ff : least_ff);
      ck = {1'b0, now} + {1'b0, delay};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALARMS; i++) begin
            slot_id_ff[i] <= '0; slot_due_ff[i] <= '0; slot_per_ff[i] <= '0;
         end
         count_ff <= '0; check_ff <= '0; min_ff <= 32'd1; max_ff <= 32'd86400;
         ov_ff <= 1'b0; pend_ff <= 1'b0; idx_ff <= '0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_MIN) min_ff <= {16'd0, csr_wdata[15:0]};
            else max_ff <= csr_wdata;
         end
         if (ctl.load_req) begin
            req_ff <= req_payload;
            hit_ff <= 1'b0; free_ok_ff <= 1'b0; nout_ff <= '0;
         end
         if (ctl.clr_idx) idx_ff <= '0;
         else if (ctl.inc_idx) idx_ff <= idx_ff + 1'b1;
         if (ctl.scan_step) begin
            if (!hit_ff && sid == req_ff.timer_id) begin
               hit_ff <= 1'b1; hit_idx_ff <= idx_ff;
            end
            if (!free_ok_ff && sid == 16'd0) begin
               free_ok_ff <= 1'b1; free_idx_ff <= idx_ff;
            end
            // A skipped command has either a zero id or a start before now.
            cst_ff <= (req_ff.timer_id == 16'd0) ? ST_BADID : ST_BADSTART;
            ccnt_ff <= (req_ff.kind == KIND_REG || req_ff.kind == KIND_DEREG)
               ? 5'(count_ff) : 5'd0;
            crem_ff <= '0;
         end
         if (ctl.apply) begin
            cst_ff <= ST_OK; crem_ff <= '0; ccnt_ff <= 5'(count_ff);
            unique case (req_ff.kind)
               KIND_REG: begin
                  if (hit_ff) cst_ff <= ST_DUP;
                  else if (!free_ok_ff) cst_ff <= ST_FULL;
                  else begin
                     slot_id_ff[free_idx_ff] <= req_ff.timer_id;
                     count_ff <= count_ff + 1'b1;
                     ccnt_ff <= 5'(count_ff + 1'b1);
                  end
               end
               KIND_DEREG: begin
                  if (!hit_ff) cst_ff <= ST_NOTREG;
                  else begin
                     slot_id_ff[hit_idx_ff] <= '0;
                     slot_due_ff[hit_idx_ff] <= '0;
                     slot_per_ff[hit_idx_ff] <= '0;
                     if (count_ff != '0) begin
                        count_ff <= count_ff - 1'b1;
                        ccnt_ff <= 5'(count_ff - 1'b1);
                     end
                  end
               end
               KIND_SET: begin
                  ccnt_ff <= '0;
                  if (!hit_ff) cst_ff <= ST_NOTREG;
                  else begin
                     slot_due_ff[hit_idx_ff] <= eff_start;
                     slot_per_ff[hit_idx_ff] <= req_ff.period_secs;
                  end
               end
               default: begin
                  ccnt_ff <= '0;
                  if (!hit_ff) cst_ff <= ST_NOTREG;
                  else begin
                     if (slot_due_ff[hit_idx_ff] == 32'd0) cst_ff <= ST_NOTSET;
                     crem_ff <= slot_due_ff[hit_idx_ff] > now
                        ? slot_due_ff[hit_idx_ff] - now : 32'd0;
                     slot_due_ff[hit_idx_ff] <= '0;
                     slot_per_ff[hit_idx_ff] <= '0;
                  end
               end
            endcase
         end
         if (ctl.tick_fire) begin
            if (per != 32'd0) slot_due_ff[idx_ff] <= sum[32] ? TMAX : sum[31:0];
            else slot_due_ff[idx_ff] <= '0;
         end
         if (ctl.rc_init) begin
            any_ff <= 1'b0; least_ff <= '0;
         end
         if (ctl.rc_slot && armed && !sts.slot_overdue) begin
            least_ff <= least_c; any_ff <= 1'b1;
         end
         if (ctl.rc_adv) begin
            slot_due_ff[idx_ff] <= adv_due;
            if (!any_ff || (adv_due - now) < least_ff) least_ff <= adv_due - now;
            any_ff <= 1'b1;
         end
         if (ctl.rc_fin) check_ff <= !any_ff ? 32'd0 : (ck[32] ? TMAX : ck[31:0]);

         // Output register: fired beats are held one deep so that the final
         // one can carry last once the walk is over. Due slots past the
         // report limit are reloaded or cleared but give no beat.
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         if (ctl.emit && nout_ff != 5'(MAX_OUT)) begin
            if (pend_ff) begin
               out_ff <= '{status: ST_OK, alarm_count: '0, secs_left: '0,
                           fired: 1'b1, fired_id: pend_id_ff, last: 1'b0};
               ov_ff <= 1'b1;
            end
            pend_ff <= 1'b1; pend_id_ff <= sid;
            nout_ff <= nout_ff + 5'd1;
         end
         if (ctl.mark_last && pend_ff) begin
            out_ff <= '{status: ST_OK, alarm_count: '0, secs_left: '0,
                        fired: 1'b1, fired_id: pend_id_ff, last: 1'b1};
            ov_ff <= 1'b1; pend_ff <= 1'b0;
         end
         if (ctl.cmd_emit) begin
            out_ff <= '{status: cst_ff, alarm_count: ccnt_ff,
                        secs_left: crem_ff, fired: 1'b0, fired_id: '0,
                        last: 1'b1};
            ov_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_payload = out_ff;
endmodule
`default_nettype wire

// ===== hdl/polled_alarm_table_core.sv =====
// ---------------------------------------------------------------------------
// Polled alarm table core
// A request beat on req_ carries a command or a tick with the current time.
// Commands give exactly one rsp_ beat; a tick at or past the check time
// gives one beat per fired alarm (up to 16), the final one marked last, or
// none at all. Undefined kinds give no beat.
// One item is worked at a time; req_stall is high from acceptance to the end.
// A command walks all 16 slots to find its slot, updates it and walks them
// again to recompute the check time. Each overdue periodic alarm adds a
// pass through the serial divider. A zero id or a start before now is
// answered without the slot walk or the recompute. A tick walks every slot,
// with an extra step for each due slot, then the recompute; its last beat
// comes after the recompute.
// While rsp_stall is high the result holds and the walk waits on it.
// csr_ writes set min_delay_secs (index 0) and max_delay_secs (index 1)
// and are always accepted.
// Synchronous reset clears all slots, the count and the check time, and
// loads the delay registers with 1 and 86400.
// ---------------------------------------------------------------------------
`default_nettype none
`include "polled_alarm_table_core_macros.svh"
module polled_alarm_table_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pat_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output pat_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [31:0]      csr_wdata
);
   import pat_pkg::*;

   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   pat_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_stall(req_stall), .out_busy(rsp_valid && rsp_stall),
      .sts(sts), .ctl(ctl));

   pat_dp u_dp (
      .clock(clock), .reset(reset), .req_payload(req_payload),
      .csr_we(csr_valid && csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .ctl(ctl), .sts(sts), .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid), .rsp_payload(rsp_payload));

   `PAT_ASSERT_IMPL(a_fire_ok, clock, reset, rsp_valid && rsp_payload.fired, rsp_payload.status == ST_OK)
   `PAT_ASSERT_NEXT(a_busy_stall, clock, reset, req_valid && !req_stall, req_stall)
   `PAT_ASSERT_IMPL(a_cmd_last, clock, reset, rsp_valid && !rsp_payload.fired, rsp_payload.last)
endmodule
`default_nettype wire

// ===== tb/polled_alarm_table_core_test.sv =====
// ---------------------------------------------------------------------------
// Alarm table core testbench
// Drives command and tick beats into the alarm table, predicts the result
// beats from a behavioral copy of the slot table, and compares every result
// beat field by field. Delay registers are changed between idle phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module polled_alarm_table_core_test;
   import pat_pkg::*;

   class alarm_scoreboard;
      logic [15:0] ids[ALARMS];
      logic [31:0] dues[ALARMS];
      logic [31:0] periods[ALARMS];
      int unsigned nreg;
      logic [31:0] check_at;
      logic [31:0] min_delay;
      logic [31:0] max_delay;
      rsp_type pending[$];
      int errors;

      function new();
         min_delay = 1;
         max_delay = 86400;
         nreg = 0;
         check_at = 0;
         errors = 0;
         for (int i = 0; i < ALARMS; i++) begin
            ids[i] = 0;
            dues[i] = 0;
            periods[i] = 0;
         end
      endfunction

      function logic [31:0] sat_sum(logic [31:0] a, logic [63:0] b);
         logic [63:0] s;
         s = {32'd0, a} + b;
         return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
      endfunction

      function int slot_of(logic [15:0] id);
         for (int i = 0; i < ALARMS; i++)
            if (ids[i] == id) return i;
         return -1;
      endfunction

      function void recompute(logic [31:0] now);
         bit any;
         logic [31:0] least, rem, delay;
         logic [63:0] k;
         any = 0;
         least = 0;
         for (int i = 0; i < ALARMS; i++) begin
            if (ids[i] == 0 || dues[i] == 0) continue;
            if (dues[i] < now && periods[i] != 0) begin
               k = {32'd0, (now - dues[i]) / periods[i]} + 1;
               dues[i] = sat_sum(dues[i], k * {32'd0, periods[i]});
            end
            rem = (dues[i] > now) ? dues[i] - now : 0;
            if (!any || rem < least) least = rem;
            any = 1;
         end
         if (!any) begin
            check_at = 0;
            return;
         end
         if (least == 0) delay = min_delay;
         else delay = (least > max_delay) ? max_delay : least;
         check_at = sat_sum(now, {32'd0, delay});
      endfunction

      function void write_reg(logic idx, logic [31:0] v);
         if (idx == CSR_MIN) min_delay = {16'd0, v[15:0]};
         else max_delay = v;
      endfunction

      // Notes one accepted request beat and queues the beats it causes.
      function void note_request(req_type r);
         rsp_type o;
         int s, n;
         logic [31:0] start;
         o = '0;
         o.last = 1;
         if (r.kind > KIND_TICK) return;
         if (r.kind == KIND_TICK) begin
            if (check_at == 0 || check_at > r.now_secs) return;
            n = 0;
            for (int i = 0; i < ALARMS; i++) begin
               if (ids[i] == 0 || dues[i] == 0 || dues[i] > r.now_secs) continue;
               if (n < MAX_OUT) begin
                  o = '0;
                  o.fired = 1;
                  o.fired_id = ids[i];
                  pending.push_back(o);
                  n++;
               end
               if (periods[i] != 0) dues[i] = sat_sum(dues[i], {32'd0, periods[i]});
               else dues[i] = 0;
            end
            if (n > 0) pending[$].last = 1;
            recompute(r.now_secs);
            return;
         end
         if (r.timer_id == 0) begin
            o.status = ST_BADID;
            if (r.kind == KIND_REG || r.kind == KIND_DEREG) o.alarm_count = nreg[4:0];
         end else if (r.kind == KIND_REG) begin
            if (slot_of(r.timer_id) >= 0) o.status = ST_DUP;
            else begin
               s = slot_of(16'd0);
               if (s < 0) o.status = ST_FULL;
               else begin
                  ids[s] = r.timer_id;
                  nreg++;
               end
            end
            o.alarm_count = nreg[4:0];
            recompute(r.now_secs);
         end else if (r.kind == KIND_DEREG) begin
            s = slot_of(r.timer_id);
            if (s < 0) o.status = ST_NOTREG;
            else begin
               ids[s] = 0;
               dues[s] = 0;
               periods[s] = 0;
               if (nreg > 0) nreg--;
            end
            o.alarm_count = nreg[4:0];
            recompute(r.now_secs);
         end else if (r.kind == KIND_SET) begin
            start = r.start_now ? r.now_secs : r.start_secs;
            if (start < r.now_secs) o.status = ST_BADSTART;
            else begin
               s = slot_of(r.timer_id);
               if (s < 0) o.status = ST_NOTREG;
               else begin
                  dues[s] = start;
                  periods[s] = r.period_secs;
               end
               recompute(r.now_secs);
            end
         end else begin
            s = slot_of(r.timer_id);
            if (s < 0) o.status = ST_NOTREG;
            else begin
               if (dues[s] == 0) o.status = ST_NOTSET;
               o.secs_left = (dues[s] > r.now_secs) ? dues[s] - r.now_secs : 0;
               dues[s] = 0;
               periods[s] = 0;
            end
            recompute(r.now_secs);
         end
         pending.push_back(o);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
         errors++;
      endtask

      task check_result(rsp_type g);
         rsp_type e;
         if (pending.size() == 0) begin
            report("unexpected beat, fired_id", 32'(g.fired_id), 32'd0);
            return;
         end
         e = pending.pop_front();
         if (g.status !== e.status) report("status", 32'(g.status), 32'(e.status));
         if (g.alarm_count !== e.alarm_count)
            report("alarm_count", 32'(g.alarm_count), 32'(e.alarm_count));
         if (g.secs_left !== e.secs_left)
            report("secs_left", g.secs_left, e.secs_left);
         if (g.fired !== e.fired) report("fired", 32'(g.fired), 32'(e.fired));
         if (g.fired_id !== e.fired_id)
            report("fired_id", 32'(g.fired_id), 32'(e.fired_id));
         if (g.last !== e.last) report("last", 32'(g.last), 32'(e.last));
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_payload;
   logic csr_valid;
   logic csr_ready;
   logic csr_index;
   logic [31:0] csr_wdata;

   alarm_scoreboard board;
   int idle_pct;
   int quiet_cycles;
   logic [31:0] clock_secs;
   logic [15:0] id_pool[8];

   polled_alarm_table_core dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      board = new();
      idle_pct = 27;
      quiet_cycles = 0;
   end

   // Result side: random stall, check every accepted beat.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else begin
         if (rsp_valid && !rsp_stall) board.check_result(rsp_payload);
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // Watchdog on cycles with no accepted beat.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // The beat stays valid after acceptance only when the next one follows.
   task automatic send(req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      // A tick may still be walking the table.
      while (board.pending.size() != 0 || req_stall) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, v);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic req_type make(logic [2:0] k, logic [15:0] id, logic [31:0] now,
                                    logic sn, logic [31:0] st, logic [31:0] per);
      req_type r;
      r.kind = k;
      r.timer_id = id;
      r.now_secs = now;
      r.start_now = sn;
      r.start_secs = st;
      r.period_secs = per;
      return r;
   endfunction

   // Mostly well-formed traffic on a small id pool with a slowly moving clock.
   task automatic random_phase(int count);
      req_type r;
      int pick;
      for (int n = 0; n < count; n++) begin
         clock_secs = clock_secs + $urandom_range(3);
         pick = int'($urandom_range(99));
         r = make(KIND_TICK, id_pool[$urandom_range(7)], clock_secs,
                  1'($urandom_range(1)), clock_secs + $urandom_range(6),
                  $urandom_range(5));
         if (pick < 15) r.kind = KIND_REG;
         else if (pick < 22) r.kind = KIND_DEREG;
         else if (pick < 42) r.kind = KIND_SET;
         else if (pick < 50) r.kind = KIND_CANCEL;
         else if (pick < 92) r.kind = KIND_TICK;
         else begin
            r.kind = 3'($urandom_range(7));
            r.timer_id = $urandom_range(3) == 0 ? 16'd0 : 16'($urandom());
            r.now_secs = $urandom();
            r.start_secs = $urandom();
            r.period_secs = $urandom();
            r.start_now = 1'($urandom_range(1));
         end
         if (n == count / 2) begin
            req_valid <= 0;
            @(posedge clock);
            while (board.pending.size() != 0) @(posedge clock);
         end
         send(r);
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_payload = '0;
      rsp_stall = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_wdata = 0;
      clock_secs = 100;
      id_pool = '{16'h0001, 16'h0002, 16'h8000, 16'hFFFF, 16'h1234, 16'h00FF,
                  16'h7FFF, 16'h5555};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part.
      send(make(KIND_REG, 16'd0, 32'd10, 1'b0, 0, 0));
      send(make(KIND_REG, 16'hFFFF, 32'd10, 1'b0, 0, 0));
      send(make(KIND_REG, 16'hFFFF, 32'd10, 1'b0, 0, 0));
      send(make(KIND_SET, 16'hFFFF, 32'd10, 1'b0, 32'd5, 0));
      send(make(KIND_SET, 16'hFFFF, 32'd10, 1'b0, 32'd12, 32'd0));
      send(make(KIND_TICK, 16'd0, 32'd11, 1'b0, 0, 0));
      send(make(KIND_TICK, 16'd0, 32'd12, 1'b0, 0, 0));
      send(make(KIND_CANCEL, 16'hFFFF, 32'd13, 1'b0, 0, 0));
      send(make(KIND_SET, 16'h0005, 32'd13, 1'b1, 0, 0));
      send(make(KIND_SET, 16'hFFFF, 32'd0, 1'b1, 0, 32'd7));
      send(make(KIND_SET, 16'hFFFF, 32'd20, 1'b0, 32'd25, 32'hFFFF_FFFF));
      send(make(KIND_CANCEL, 16'hFFFF, 32'd21, 1'b0, 0, 0));
      send(make(KIND_SET, 16'hFFFF, 32'hFFFF_FFF0, 1'b0, 32'hFFFF_FFFF, 32'd3));
      send(make(KIND_TICK, 16'd0, 32'hFFFF_FFFF, 1'b0, 0, 0));
      send(make(3'd5, 16'h1, 32'd0, 1'b0, 0, 0));
      send(make(3'd7, 16'h1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send(make(KIND_DEREG, 16'hFFFF, 32'd30, 1'b0, 0, 0));
      send(make(KIND_DEREG, 16'hFFFF, 32'd30, 1'b0, 0, 0));
      // Fill the table past capacity, then fire many at once.
      for (int i = 1; i <= 17; i++)
         send(make(KIND_REG, 16'(i), 32'd40, 1'b0, 0, 0));
      for (int i = 1; i <= 16; i++)
         send(make(KIND_SET, 16'(i), 32'd40, 1'b0, 32'd50, (i % 2) ? 32'd10 : 32'd0));
      send(make(KIND_TICK, 16'd0, 32'd50, 1'b0, 0, 0));
      send(make(KIND_SET, 16'd1, 32'd60, 1'b0, 32'd60, 32'd4));
      send(make(KIND_TICK, 16'd0, 32'd500, 1'b0, 0, 0));
      for (int i = 1; i <= 16; i++)
         send(make(KIND_DEREG, 16'(i), 32'd600, 1'b0, 0, 0));
      drain();

      write_csr(CSR_MIN, 32'hFFFF);
      write_csr(~CSR_MIN, 32'd1);
      random_phase(45);
      drain();
      write_csr(CSR_MIN, 32'd3);
      write_csr(~CSR_MIN, 32'hFFFF_FFFF);
      random_phase(45);
      drain();
      write_csr(CSR_MIN, 32'hABCD_0001);
      write_csr(~CSR_MIN, 32'd5);
      idle_pct = 0;
      random_phase(25);
      idle_pct = 27;
      random_phase(25);
      drain();

      if (board.errors == 0 && board.pending.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
